// File: hw/rtl/ira_pkg.sv
package ira_pkg;

    localparam int MAX_ROOMS_DEF = 1024;
    localparam int DEP_W = 32;
    localparam int OUT_W = 11;

    typedef struct packed {
        logic [31:0] arrival;
        logic [31:0] departure;
    } in_word_t;

    typedef struct packed {
        logic [10:0] room;
        logic [10:0] rooms_used;
        logic        overflow;
    } out_word_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic decide;
        logic rd_kids;
        logic cmp_down;
        logic rd_parent;
        logic cmp_up;
    } ira_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic done;
        logic reuse_down;
    } ira_sts_t;

endpackage

// File: hw/rtl/ira_ctrl.sv
module ira_ctrl
    import ira_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_fire,
    input  logic      out_fire,
    input  ira_sts_t  sts,
    output ira_cmd_t  cmd,
    output logic      in_ready,
    output logic      out_valid
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_RD0   = 7'b0000010,
        S_DEC   = 7'b0000100,
        S_DNRD  = 7'b0001000,
        S_DNCMP = 7'b0010000,
        S_UPRD  = 7'b0100000,
        S_UPCMP = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        out_valid_next = out_valid_reg && !out_fire;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.capture = 1'b1;
                    state_next = S_RD0;
                end
            end
            S_RD0:
                state_next = S_DEC;
            S_DEC:
            begin
                cmd.decide = 1'b1;
                if (sts.done)
                begin
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
                else if (sts.reuse_down)
                begin
                    state_next = S_DNRD;
                end
                else
                begin
                    state_next = S_UPRD;
                end
            end
            S_DNRD:
            begin
                cmd.rd_kids = 1'b1;
                state_next = S_DNCMP;
            end
            S_DNCMP:
            begin
                cmd.cmp_down = 1'b1;
                state_next = S_DNRD;
                if (sts.done)
                begin
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_UPRD:
            begin
                cmd.rd_parent = 1'b1;
                state_next = S_UPCMP;
            end
            S_UPCMP:
            begin
                cmd.cmp_up = 1'b1;
                state_next = S_UPRD;
                if (sts.done)
                begin
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // a new word may enter once the previous result has left the output register
    assign in_ready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;

endmodule

// File: hw/rtl/ira_datapath.sv
module ira_datapath
    import ira_pkg::*;
#(
    parameter int MAX_ROOMS = MAX_ROOMS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  in_word_t  in_word,
    input  ira_cmd_t  cmd,
    output ira_sts_t  sts,
    output out_word_t out_word
);

    localparam int AW = $clog2(MAX_ROOMS);
    localparam int CW = $clog2(MAX_ROOMS + 1);

    typedef struct packed {
        logic [DEP_W-1:0] dep;
        logic [CW-1:0]    room;
    } slot_t;

    // heap storage, two read ports and one write port
    slot_t mem [MAX_ROOMS];
    slot_t rd_a_reg, rd_b_reg;
    logic [AW-1:0] ra_addr, rb_addr, wr_addr;
    logic          wr_en;
    slot_t         wr_data;

    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    pos_reg, pos_next;
    slot_t            item_reg, item_next;
    logic [DEP_W-1:0] arr_reg;
    logic [DEP_W-1:0] dep_in_reg;
    out_word_t        res_reg, res_next;

    // final placement when sift up reaches the root
    logic root_pend_reg;

    function automatic logic before_f(slot_t x, slot_t y);
        if (x.dep != y.dep)
            return x.dep < y.dep;
        return x.room < y.room;
    endfunction

    logic [CW:0] lidx, ridx;
    logic [CW-1:0] parent;
    logic l_ok, r_ok, take_l, take_r, swap_up;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_a_reg <= mem[ra_addr];
        rd_b_reg <= mem[rb_addr];
    end

    // child and parent positions of the current hole
    always_comb
    begin
        lidx   = {pos_reg, 1'b1};
        ridx   = lidx + 1'b1;
        parent = (pos_reg - 1'b1) >> 1;
        l_ok   = lidx < (CW+1)'(count_reg);
        r_ok   = ridx < (CW+1)'(count_reg);
        take_l = l_ok && before_f(rd_a_reg, item_reg) &&
                 !(r_ok && before_f(rd_b_reg, rd_a_reg));
        take_r = r_ok && before_f(rd_b_reg, item_reg) && before_f(rd_b_reg, rd_a_reg);
        swap_up = before_f(item_reg, rd_a_reg);
    end

    // sift control: the moving item is held in item_reg, written once at the end
    always_comb
    begin
        count_next = count_reg;
        pos_next   = pos_reg;
        item_next  = item_reg;
        res_next   = res_reg;
        ra_addr    = '0;
        rb_addr    = '0;
        wr_en      = 1'b0;
        wr_addr    = pos_reg[AW-1:0];
        wr_data    = item_reg;
        sts        = '0;
        // root slot of a finished sift up, written the cycle after
        if (root_pend_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_data = item_reg;
        end
        if (cmd.rd_kids)
        begin
            ra_addr = lidx[AW-1:0];
            rb_addr = ridx[AW-1:0];
        end
        if (cmd.rd_parent)
            ra_addr = parent[AW-1:0];
        if (cmd.decide)
        begin
            if (count_reg != '0 && rd_a_reg.dep < arr_reg)
            begin
                sts.reuse_down = 1'b1;
                item_next = '{dep: dep_in_reg, room: rd_a_reg.room};
                res_next  = '{room: OUT_W'(rd_a_reg.room),
                              rooms_used: OUT_W'(count_reg), overflow: 1'b0};
                pos_next  = '0;
            end
            else if (count_reg < CW'(MAX_ROOMS))
            begin
                count_next = count_reg + 1'b1;
                item_next = '{dep: dep_in_reg, room: count_reg + 1'b1};
                res_next  = '{room: OUT_W'(count_reg + 1'b1),
                              rooms_used: OUT_W'(count_reg + 1'b1), overflow: 1'b0};
                pos_next  = count_reg;
                if (count_reg == '0)
                begin
                    sts.done = 1'b1;
                    wr_en = 1'b1;
                    wr_addr = '0;
                    wr_data = '{dep: dep_in_reg, room: CW'(1)};
                end
            end
            else
            begin
                sts.done = 1'b1;
                res_next = '{room: '0, rooms_used: OUT_W'(count_reg), overflow: 1'b1};
            end
        end
        if (cmd.cmp_down)
        begin
            wr_en = 1'b1;
            if (take_l)
            begin
                wr_data  = rd_a_reg;
                pos_next = lidx[CW-1:0];
            end
            else if (take_r)
            begin
                wr_data  = rd_b_reg;
                pos_next = ridx[CW-1:0];
            end
            else
            begin
                sts.done = 1'b1;
            end
        end
        if (cmd.cmp_up)
        begin
            wr_en = 1'b1;
            if (pos_reg != '0 && swap_up)
            begin
                wr_data  = rd_a_reg;
                pos_next = parent;
                if (parent == '0)
                begin
                    sts.done = 1'b1;
                    // the item itself lands in the root slot on the next cycle
                end
            end
            else
            begin
                sts.done = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            root_pend_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            root_pend_reg <= cmd.cmp_up && pos_reg != '0 && swap_up && parent == '0;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg  <= pos_next;
        item_reg <= item_next;
        res_reg  <= res_next;
        if (cmd.capture)
        begin
            arr_reg    <= in_word.arrival;
            dep_in_reg <= in_word.departure;
        end
    end

    assign out_word = res_reg;

endmodule

// File: hw/rtl/interval_room_allocator.sv
// Interval room allocator: each booking word (arrival, departure) must come in
// nondecreasing arrival order and gets one result word with its room, the
// running room count and an overflow flag. Rooms are tracked in a min-heap of
// (departure, room) held in a MAX_ROOMS-entry memory; one booking at a time is
// processed. Each heap level walked by the sift takes one memory read and then
// one compare and write. A new booking is accepted only once the result has been
// taken. No clearing pass is needed after reset.
module interval_room_allocator
    import ira_pkg::*;
#(
    parameter int MAX_ROOMS = MAX_ROOMS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_word_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_data
);

    ira_cmd_t cmd;
    ira_sts_t sts;
    logic in_fire, out_fire;

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;

    ira_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_fire(out_fire),
        .sts(sts), .cmd(cmd), .in_ready(in_ready), .out_valid(out_valid)
    );

    ira_datapath #(.MAX_ROOMS(MAX_ROOMS)) u_dp (
        .clk(clk), .rst_n(rst_n), .in_word(in_data), .cmd(cmd), .sts(sts),
        .out_word(out_data)
    );

    // no new word while a result waits
    assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> !in_ready)
        else $error("input accepted while result pending");

    // a result word never reports a room and an overflow together
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.overflow |-> out_data.room == '0)
        else $error("overflow with room");

    // an accepted word produces no result in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n) in_fire |=> !out_valid)
        else $error("result too early");

endmodule
